// File: rtl/core/tpaf_pkg.sv
`default_nettype none
package tpaf_pkg;

    // register reset values
    localparam int PERIOD_RST  = 20000;
    localparam int HALF_RST    = 10000;
    localparam int MARGIN_RST  = 200;
    localparam int COMP_RST    = 0;
    localparam int PULSE_RST   = 100;
    localparam int REPEAT_RST  = 2;

    localparam int BUFFER_WORDS_DEF = 64;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int REP_W = 5;
    localparam int OUT_IDX_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 3'd5;

    // percentage saturates at 200 and is halved
    localparam logic [7:0] PCT_MAX = 8'd200;
    localparam logic [6:0] PCT_HALF_MAX = 7'd100;

    // floor(x / 100) = (x * 83887) >> 23, exact for 16-bit x
    localparam int RECIP_100 = 83887;
    localparam int RECIP_SHIFT = 23;
    localparam int QUOT_W = 10;

    localparam logic [REP_W-1:0] GROUPS_MAX = 5'd16;

    typedef enum logic {
        OP_SET    = 1'b0,
        OP_REFILL = 1'b1
    } t_op;

    typedef logic signed [17:0] t_dem;
    typedef logic signed [19:0] t_s20;

    localparam t_dem DEM_NEG_RST = 18'(PERIOD_RST + COMP_RST);
    localparam t_dem DEM_POS_RST = 18'(HALF_RST + COMP_RST);

    typedef struct packed {
        logic [15:0]      period;
        logic [15:0]      half;
        logic [15:0]      margin;
        logic [15:0]      comp;
        logic [15:0]      pulse;
        logic [REP_W-1:0] repeat_cnt;
    } t_cfg;

    // one refill job: on, off, on, off words and the group count
    typedef struct packed {
        logic [3:0][15:0] words;
        logic [REP_W-1:0] groups;
    } t_job;

    function automatic logic [15:0] sat16(input t_s20 v);
        logic [15:0] r;
        if (v < 0) begin
            r = 16'd0;
        end else if (v > 20'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic t_s20 s20u(input logic [15:0] v);
        return signed'({4'd0, v});
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/triac_phase_angle_firing_unit.sv
`default_nettype none
// Triac phase-angle firing scheduler. A set item (operation 0) latches two
// firing times from the percentage; it goes through three register stages
// (input, period/100 times percentage, demand update) and gives no result. A
// refill item (operation 1) passes the same input and product stages, is conditioned
// against the latched times, and then makes 4 * groups compare words, one
// per cycle from the word emitter while the output is not stalled, where groups is
// repeat_count (at most 16) on the first refill and one fewer afterwards.
// Items enter one per cycle; the input stalls only while a refill with words waits
// for the emitter to finish the previous refill, which holds 4 * groups words
// (up to 64). Ring positions wrap at BUFFER_WORDS and carry on across refills.
module triac_phase_angle_firing_unit import tpaf_pkg::*; #(
    parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_operation,
    input  wire logic [7:0]            i_percentage,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [OUT_IDX_W-1:0]       o_word_index,
    output logic [15:0]                o_compare_value,
    output logic                       o_last
);

    t_cfg r_cfg;
    t_job job;
    logic job_valid;
    logic job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period     <= 16'(PERIOD_RST);
            r_cfg.half       <= 16'(HALF_RST);
            r_cfg.margin     <= 16'(MARGIN_RST);
            r_cfg.comp       <= 16'(COMP_RST);
            r_cfg.pulse      <= 16'(PULSE_RST);
            r_cfg.repeat_cnt <= REP_W'(REPEAT_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PERIOD: r_cfg.period     <= i_cfg_data;
                CFG_HALF:   r_cfg.half       <= i_cfg_data;
                CFG_MARGIN: r_cfg.margin     <= i_cfg_data;
                CFG_COMP:   r_cfg.comp       <= i_cfg_data;
                CFG_PULSE:  r_cfg.pulse      <= i_cfg_data;
                CFG_REPEAT: r_cfg.repeat_cnt <= i_cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    tpaf_demand u_demand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_operation  (i_operation),
        .i_percentage (i_percentage),
        .o_in_stall   (o_in_stall),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_ready  (job_ready)
    );

    tpaf_emitter #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_job_ready     (job_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_word_index    (o_word_index),
        .o_compare_value (o_compare_value),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

// File: rtl/core/tpaf_demand.sv
`default_nettype none
module tpaf_demand import tpaf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_in_valid,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_percentage,
    output logic             o_in_stall,
    output logic             o_job_valid,
    output t_job             o_job,
    input  wire logic        i_job_ready
);

    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [6:0]        r_s1_pct;
    logic              r_s2_valid;
    t_op               r_s2_op;
    logic [15:0]       r_s2_prod;
    logic [QUOT_W-1:0] r_quot;
    t_dem              r_dem_neg;
    t_dem              r_dem_pos;
    logic              r_first;

    logic [32:0]       quot_prod;
    logic [QUOT_W-1:0] n_quot;
    logic [6:0]        pct_half;
    logic [16:0]       prod_full;
    t_s20              t_fire;
    t_dem              n_dem_neg;
    t_dem              n_dem_pos;
    t_s20              s_n, s_q, s_per, s_half, s_mar, s_comp, s_pw;
    logic              cap, off, pin;
    t_s20              w0, w1, w2, w3;
    logic [REP_W-1:0]  grp_sat, grp;
    logic              has_words;
    logic              advance;

    // period / 100 only depends on config, so it is kept up to date every cycle
    assign quot_prod = 33'(i_cfg.period) * 33'(RECIP_100);
    assign n_quot = quot_prod[RECIP_SHIFT +: QUOT_W];

    assign pct_half = (i_percentage > PCT_MAX) ? PCT_HALF_MAX : i_percentage[7:1];
    assign prod_full = 17'(r_quot) * 17'(r_s1_pct);

    always_comb begin
        t_fire = s20u(i_cfg.period) - s20u(r_s2_prod);
        n_dem_neg = 18'(t_fire + s20u(i_cfg.comp));
        n_dem_pos = 18'(t_fire - s20u(i_cfg.half) + s20u(i_cfg.comp));
    end

    always_comb begin
        s_n    = 20'(r_dem_neg);
        s_q    = 20'(r_dem_pos);
        s_per  = s20u(i_cfg.period);
        s_half = s20u(i_cfg.half);
        s_mar  = s20u(i_cfg.margin);
        s_comp = s20u(i_cfg.comp);
        s_pw   = s20u(i_cfg.pulse);

        cap = (s_n >= s_per - s_mar) && (s_q >= s_half - s_mar);
        off = cap && (s_n >= s_per) && (s_q >= s_half);
        pin = (s_n <= s_half + s_mar + s_comp) && (s_q <= s_mar + s_comp);

        priority if (cap) begin
            w0 = s_per - s_mar;
            w1 = s_per - s_mar + s_pw;
            w2 = s_half - s_mar;
            w3 = s_half - s_mar + s_pw;
        end else if (pin) begin
            w0 = s_half + s_comp;
            w1 = s_half + s_comp + s_mar;
            w2 = s_comp;
            w3 = s_comp + s_mar;
        end else begin
            w0 = s_n;
            w1 = s_n + s_pw;
            w2 = s_q;
            w3 = s_q + s_pw;
        end
    end

    always_comb begin
        grp_sat = (i_cfg.repeat_cnt > GROUPS_MAX) ? GROUPS_MAX : i_cfg.repeat_cnt;
        if (r_first) begin
            grp = grp_sat;
        end else begin
            grp = (grp_sat == '0) ? '0 : grp_sat - 1'b1;
        end
        has_words = !off && (grp != '0);
    end

    assign o_job.words[0] = sat16(w0);
    assign o_job.words[1] = sat16(w1);
    assign o_job.words[2] = sat16(w2);
    assign o_job.words[3] = sat16(w3);
    assign o_job.groups   = grp;

    assign o_job_valid = r_s2_valid && (r_s2_op == OP_REFILL) && has_words;
    // the whole pipe holds while a refill waits for the emitter
    assign advance = !(o_job_valid && !i_job_ready);
    assign o_in_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_first <= 1'b1;
            r_dem_neg <= DEM_NEG_RST;
            r_dem_pos <= DEM_POS_RST;
        end else if (advance) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                if (r_s2_op == OP_SET) begin
                    r_dem_neg <= n_dem_neg;
                    r_dem_pos <= n_dem_pos;
                end else begin
                    r_first <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        if (advance) begin
            r_s1_op <= t_op'(i_operation);
            r_s1_pct <= pct_half;
            r_s2_op <= r_s1_op;
            r_s2_prod <= prod_full[15:0];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tpaf_emitter.sv
`default_nettype none
module tpaf_emitter import tpaf_pkg::*; #(
    parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_job_valid,
    input  wire t_job                 i_job,
    output logic                      o_job_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [OUT_IDX_W-1:0]      o_word_index,
    output logic [15:0]               o_compare_value,
    output logic                      o_last
);

    localparam int IW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
    localparam int XW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;
    localparam logic [IW-1:0] IDX_TOP = IW'(BUFFER_WORDS - 1);

    logic             r_busy;
    logic [3:0][15:0] r_words;
    logic [1:0]       r_k;
    logic [REP_W-1:0] r_left;
    logic [IW-1:0]    r_widx;

    logic             fire;
    logic             is_last;
    logic             load;
    logic [XW-1:0]    widx_ext;

    assign fire = r_busy && !i_out_stall;
    assign is_last = (r_k == 2'd3) && (r_left == REP_W'(1));
    assign o_job_ready = !r_busy || (fire && is_last);
    assign load = i_job_valid && o_job_ready;

    assign widx_ext = XW'(r_widx);
    assign o_out_valid = r_busy;
    assign o_word_index = widx_ext[OUT_IDX_W-1:0];
    assign o_compare_value = r_words[r_k];
    assign o_last = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_widx <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (fire && is_last) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_widx <= (r_widx == IDX_TOP) ? '0 : r_widx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_words <= i_job.words;
            r_k <= 2'd0;
            r_left <= i_job.groups;
        end else if (fire) begin
            r_k <= r_k + 1'b1;
            if (r_k == 2'd3) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tpaf_checker.sv
`default_nettype none
module tpaf_checker import tpaf_pkg::*; #(
    parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [OUT_IDX_W-1:0] o_word_index,
    input wire logic [15:0]          o_compare_value,
    input wire logic                 o_last
);

    localparam logic CHECK_WRAP = (BUFFER_WORDS == 64);

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_word_index) && $stable(o_compare_value)
            && $stable(o_last))
        else $error("stalled output item changed");

    // words of one refill come without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("refill burst broke before its last word");

    // ring position steps by one inside a burst
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CHECK_WRAP && o_out_valid && !i_out_stall && !o_last |=>
            o_word_index == OUT_IDX_W'($past(o_word_index) + 1'b1))
        else $error("ring position did not advance by one");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind triac_phase_angle_firing_unit tpaf_checker #(
    .BUFFER_WORDS (BUFFER_WORDS)
) u_tpaf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_word_index    (o_word_index),
    .o_compare_value (o_compare_value),
    .o_last          (o_last)
);
`default_nettype wire

// File: sim/triac_phase_angle_firing_unit_tb.sv
`timescale 1ns / 1ps
module triac_phase_angle_firing_unit_tb;
    import tpaf_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int PIPE_SETTLE = 12;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [OUT_IDX_W-1:0] index;
        logic [15:0]          value;
        logic                 last;
    } t_word_exp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation = 1'b0;
    logic [7:0]            i_percentage = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OUT_IDX_W-1:0]  o_word_index;
    logic [15:0]           o_compare_value;
    logic                  o_last;

    // firing model state
    int cfg_period, cfg_half, cfg_margin, cfg_comp, cfg_pulse, cfg_repeat;
    int dem_neg, dem_pos;
    bit first_refill;
    int ring_pos;
    t_word_exp pending_words[$];

    int error_count = 0;
    int words_checked = 0;
    int items_sent = 0;
    int refills_sent = 0;
    int config_sets = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    triac_phase_angle_firing_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_percentage    (i_percentage),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_word_index    (o_word_index),
        .o_compare_value (o_compare_value),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    task automatic schedule_firing(input logic op, input logic [7:0] pct);
        int per, half, mar, comp, pw, p, t, n, q, groups;
        int w[4];
        t_word_exp e;
        per  = cfg_period;
        half = cfg_half;
        mar  = cfg_margin;
        comp = cfg_comp;
        pw   = cfg_pulse;
        if (op == OP_SET) begin
            p = ((pct > PCT_MAX) ? int'(PCT_MAX) : int'(pct)) / 2;
            t = per - (per / 100) * p;
            dem_neg = t + comp;
            dem_pos = t - half + comp;
            return;
        end
        n = dem_neg;
        q = dem_pos;
        groups = (cfg_repeat > 16) ? 16 : cfg_repeat;
        if (!first_refill) begin
            groups = (groups > 0) ? groups - 1 : 0;
        end
        first_refill = 1'b0;
        if (n >= per - mar && q >= half - mar) begin
            // both times past the end of the half cycle: gate stays off
            if (n >= per && q >= half) begin
                return;
            end
            w[0] = per - mar;
            w[1] = w[0] + pw;
            w[2] = half - mar;
            w[3] = w[2] + pw;
        end else if (n <= half + mar + comp && q <= mar + comp) begin
            w[0] = half + comp;
            w[1] = half + comp + mar;
            w[2] = comp;
            w[3] = comp + mar;
        end else begin
            w[0] = n;
            w[1] = n + pw;
            w[2] = q;
            w[3] = q + pw;
        end
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                e.index = ring_pos[OUT_IDX_W-1:0];
                e.value = (w[k] < 0) ? 16'd0 : (w[k] > 65535) ? 16'hFFFF : 16'(w[k]);
                e.last  = (g + 1 == groups) && (k == 3);
                pending_words.push_back(e);
                ring_pos = (ring_pos + 1) % BUFFER_WORDS_DEF;
            end
        end
    endtask

    // sender: bursts of random length separated by random gaps
    task automatic send_item(input logic op, input logic [7:0] pct);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_percentage <= pct;
        do @(posedge i_clk); while (o_in_stall);
        schedule_firing(op, pct);
        items_sent++;
        if (op == OP_REFILL) refills_sent++;
    endtask

    // stop sending and wait for every expected word, then let the pipeline settle
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // writes all registers in order, plus the two unused indexes
    task automatic apply_config(input logic [15:0] per, input logic [15:0] half,
                                input logic [15:0] mar, input logic [15:0] comp,
                                input logic [15:0] pw, input logic [15:0] rep_data);
        logic [15:0] d;
        for (int i = 0; i < 8; i++) begin
            case (CFG_IDX_W'(i))
                CFG_PERIOD: d = per;
                CFG_HALF:   d = half;
                CFG_MARGIN: d = mar;
                CFG_COMP:   d = comp;
                CFG_PULSE:  d = pw;
                CFG_REPEAT: d = rep_data;
                default:    d = 16'($urandom());
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= d;
            @(posedge i_clk);
            case (CFG_IDX_W'(i))
                CFG_PERIOD: cfg_period = d;
                CFG_HALF:   cfg_half   = d;
                CFG_MARGIN: cfg_margin = d;
                CFG_COMP:   cfg_comp   = d;
                CFG_PULSE:  cfg_pulse  = d;
                CFG_REPEAT: cfg_repeat = d[REP_W-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
        config_sets++;
    endtask

    // normal, capped, pinned and off cases at reset register values
    task automatic test_demand_cases();
        send_item(OP_SET, 8'd60);
        send_item(OP_REFILL, 8'd0);
        send_item(OP_REFILL, 8'd17);
        send_item(OP_SET, 8'd2);
        send_item(OP_REFILL, 8'd0);
        send_item(OP_SET, 8'd200);
        send_item(OP_REFILL, 8'd0);
        send_item(OP_SET, 8'd255);
        send_item(OP_REFILL, 8'hFF);
        send_item(OP_SET, 8'd100);
        send_item(OP_REFILL, 8'd0);
        send_item(OP_SET, 8'd0);
        send_item(OP_REFILL, 8'd0);
        send_item(OP_SET, 8'd1);
        send_item(OP_REFILL, 8'd0);
        drain_words();
    endtask

    // words clipped at 0 and at 65535
    task automatic test_word_saturation();
        apply_config(16'd100, 16'd100, 16'd300, 16'd0, 16'd50, 16'd2);
        send_item(OP_SET, 8'd0);
        send_item(OP_REFILL, 8'd0);
        drain_words();
        apply_config(16'hFFFF, 16'd32768, 16'd0, 16'd40000, 16'hFFFF, 16'd3);
        send_item(OP_SET, 8'd200);
        send_item(OP_REFILL, 8'd0);
        send_item(OP_SET, 8'd100);
        send_item(OP_REFILL, 8'd0);
        drain_words();
    endtask

    // repeat count of zero and above range; upper data bits must be dropped
    task automatic test_repeat_extremes();
        apply_config(16'd20000, 16'd10000, 16'd200, 16'd0, 16'd100, 16'hFFE0);
        send_item(OP_SET, 8'd60);
        send_item(OP_REFILL, 8'd0);
        drain_words();
        apply_config(16'd20000, 16'd10000, 16'd200, 16'd0, 16'd100, 16'h001F);
        send_item(OP_REFILL, 8'd0);
        drain_words();
    endtask

    function automatic logic [15:0] pick_u16(input logic [15:0] typical);
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'd1;
            1:       v = 16'hFFFF;
            2:       v = typical;
            3:       v = 16'($urandom_range(0, 1000));
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    task automatic test_random_traffic();
        logic [15:0] per, half, mar, comp, pw, rep;
        logic [7:0] pct;
        logic op;
        for (int r = 0; r < 6; r++) begin
            per  = pick_u16(16'd20000);
            half = ($urandom_range(0, 2) == 0) ? pick_u16(16'd10000) : per / 2 + 16'd0;
            if (half == 0) half = 16'd1;
            mar  = ($urandom_range(0, 4) == 0) ? 16'd0 : pick_u16(16'd200);
            comp = ($urandom_range(0, 3) == 0) ? 16'd0 : pick_u16(16'd50);
            pw   = pick_u16(16'd100);
            rep  = {11'($urandom()), 5'($urandom_range(0, 4) == 0 ?
                                         $urandom_range(0, 31) : $urandom_range(1, 6))};
            if (r == 0) rep = {11'd0, 5'd16};
            apply_config(per, half, mar, comp, pw, rep);
            for (int i = 0; i < 42; i++) begin
                op = ($urandom_range(0, 99) < 45) ? OP_REFILL : OP_SET;
                case ($urandom_range(0, 9))
                    0:       pct = 8'd0;
                    1:       pct = 8'd200;
                    2:       pct = 8'd255;
                    3:       pct = 8'($urandom_range(201, 255));
                    default: pct = 8'($urandom_range(0, 200));
                endcase
                send_item(op, pct);
                if (r == 2 && i == 20) drain_words();
            end
            drain_words();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_word_exp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: index %0d value %0d last %0b",
                       o_word_index, o_compare_value, o_last);
                error_count++;
            end else begin
                e = pending_words.pop_front();
                words_checked++;
                if (o_word_index !== e.index) begin
                    $error("word_index mismatch: expected %0d, got %0d", e.index, o_word_index);
                    error_count++;
                end
                if (o_compare_value !== e.value) begin
                    $error("compare_value mismatch: expected %0d, got %0d",
                           e.value, o_compare_value);
                    error_count++;
                end
                if (o_last !== e.last) begin
                    $error("last mismatch: expected %0b, got %0b", e.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern: free, random, periodic or mostly stalled
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            2:       i_out_stall <= (stall_tick % 4) == 0;
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** triac_phase_angle_firing_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        cfg_period   = PERIOD_RST;
        cfg_half     = HALF_RST;
        cfg_margin   = MARGIN_RST;
        cfg_comp     = COMP_RST;
        cfg_pulse    = PULSE_RST;
        cfg_repeat   = REPEAT_RST;
        dem_neg      = PERIOD_RST + COMP_RST;
        dem_pos      = HALF_RST + COMP_RST;
        first_refill = 1'b1;
        ring_pos     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_demand_cases();
        test_word_saturation();
        test_repeat_extremes();
        test_random_traffic();

        drain_words();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items (%0d refills) over %0d register settings.",
                 items_sent, refills_sent, config_sets);
        $display("Checked %0d compare words, %0d errors.", words_checked, error_count);
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("** triac_phase_angle_firing_unit: PASSED **");
        end else begin
            $display("** triac_phase_angle_firing_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/tpaf_pkg.sv
rtl/core/tpaf_demand.sv
rtl/core/tpaf_emitter.sv
rtl/core/triac_phase_angle_firing_unit.sv
rtl/core/tpaf_checker.sv
sim/triac_phase_angle_firing_unit_tb.sv
